// ===== sv/page_frame_stack_allocator_core_assert.svh =====
// Assertion macros shared by the allocator modules.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef PAGE_FRAME_STACK_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PFSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/pfsa_pkg.sv =====
package pfsa_pkg;

  // Result status codes.
  localparam logic [2:0] STATUS_POPPED         = 3'd0;
  localparam logic [2:0] STATUS_BUMPED         = 3'd1;
  localparam logic [2:0] STATUS_BUMP_EXHAUSTED = 3'd2;
  localparam logic [2:0] STATUS_FREED          = 3'd3;
  localparam logic [2:0] STATUS_PROTECTED      = 3'd4;
  localparam logic [2:0] STATUS_STACK_FULL     = 3'd5;

  // Request operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGING_ONLINE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_END_FRAME = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BUMP_START_FRAME = 2'd2;

  // Protection limits, in frames.
  localparam int GUARD_FRAMES     = 16;
  localparam int LOW_LIMIT_FRAME  = 32;
  localparam int KERNEL_LOW_FRAME = 256;
  localparam int KERNEL_LOW_BITS  = 9;

  // Shift command broadcast to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== sv/pfsa_req_if.sv =====
interface pfsa_req_if #(
  parameter int FRAME_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [FRAME_BITS-1:0] frame_in;

  modport source (output valid, output operation, output frame_in, input ready);
  modport sink (input valid, input operation, input frame_in, output ready);
endinterface

// ===== sv/pfsa_rsp_if.sv =====
interface pfsa_rsp_if #(
  parameter int FRAME_BITS = 20,
  parameter int COUNT_BITS = 11
);
  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] frame_out;
  logic [2:0]            status;
  logic [COUNT_BITS-1:0] free_count;

  modport source (output valid, output frame_out, output status, output free_count,
                  input ready);
  modport sink (input valid, input frame_out, input status, input free_count,
                output ready);
endinterface

// ===== sv/pfsa_cfg_if.sv =====
interface pfsa_cfg_if #(
  parameter int DATA_BITS  = 20,
  parameter int INDEX_BITS = 2
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/pfsa_cell.sv =====
module pfsa_cell #(
  parameter int FRAME_BITS = 20
) (
  input  logic                  clk,
  input  pfsa_pkg::cell_ctl_t   ctl,
  input  logic [FRAME_BITS-1:0] from_left,
  input  logic [FRAME_BITS-1:0] from_right,
  output logic [FRAME_BITS-1:0] value
);
  import pfsa_pkg::*;

  // A push moves every entry one place deeper, a pop one place toward the top.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value <= from_left;
    end else if (ctl.pop) begin
      value <= from_right;
    end
  end
endmodule

// ===== sv/pfsa_ctrl.sv =====
`include "page_frame_stack_allocator_core_assert.svh"

module pfsa_ctrl #(
  parameter int STACK_DEPTH = 1024,
  parameter int FRAME_BITS  = 20,
  parameter int COUNT_BITS  = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                operation,
  input  logic [FRAME_BITS-1:0]               frame_in,
  input  logic [FRAME_BITS-1:0]               top_entry,
  input  logic                                cfg_we,
  input  logic [pfsa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FRAME_BITS-1:0]               cfg_data,
  output pfsa_pkg::cell_ctl_t                 ctl,
  output logic [FRAME_BITS-1:0]               res_frame,
  output logic [2:0]                          res_status,
  output logic [COUNT_BITS-1:0]               res_count
);
  import pfsa_pkg::*;

  localparam int CMP_BITS = (FRAME_BITS > KERNEL_LOW_BITS) ? FRAME_BITS : KERNEL_LOW_BITS;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

  logic                  paging_online;
  logic [FRAME_BITS-1:0] kernel_end_frame;
  logic [FRAME_BITS-1:0] bump_start_frame;
  logic [FRAME_BITS-1:0] bump_frame;
  logic [FRAME_BITS-1:0] bump_frame_next;
  logic [COUNT_BITS-1:0] stack_top;
  logic [COUNT_BITS-1:0] stack_top_next;
  logic [FRAME_BITS-1:0] guard_limit;
  logic [CMP_BITS-1:0]   frame_wide;
  logic [CMP_BITS-1:0]   kernel_wide;
  logic                  is_protected;
  logic                  stack_empty;
  logic                  stack_full;

  assign stack_empty = (stack_top == '0);
  assign stack_full  = (stack_top == COUNT_BITS'(STACK_DEPTH));
  assign guard_limit = (bump_frame >= FRAME_BITS'(GUARD_FRAMES)) ?
                       (bump_frame - FRAME_BITS'(GUARD_FRAMES)) : '0;
  assign frame_wide  = CMP_BITS'(frame_in);
  assign kernel_wide = CMP_BITS'(kernel_end_frame);

  assign is_protected = (frame_in > guard_limit) ||
                        ((frame_wide > CMP_BITS'(KERNEL_LOW_FRAME)) &&
                         (frame_wide < kernel_wide)) ||
                        (frame_in < FRAME_BITS'(LOW_LIMIT_FRAME));

  always_comb begin
    ctl.push        = 1'b0;
    ctl.pop         = 1'b0;
    res_frame       = '0;
    res_status      = STATUS_FREED;
    bump_frame_next = bump_frame;
    stack_top_next  = stack_top;
    if (operation == OP_ALLOC) begin
      if (!paging_online || stack_empty) begin
        if (bump_frame == FRAME_MAX) begin
          res_status = STATUS_BUMP_EXHAUSTED;
        end else begin
          bump_frame_next = bump_frame + 1'b1;
          res_frame       = bump_frame + 1'b1;
          res_status      = STATUS_BUMPED;
        end
      end else begin
        ctl.pop        = accept;
        res_frame      = top_entry;
        res_status     = STATUS_POPPED;
        stack_top_next = stack_top - 1'b1;
      end
    end else begin
      if (is_protected) begin
        res_status = STATUS_PROTECTED;
      end else if (stack_full) begin
        res_status = STATUS_STACK_FULL;
      end else begin
        ctl.push       = accept;
        res_status     = STATUS_FREED;
        stack_top_next = stack_top + 1'b1;
      end
    end
  end

  assign res_count = stack_top_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      paging_online    <= 1'b0;
      kernel_end_frame <= '0;
      bump_start_frame <= '0;
      bump_frame       <= '0;
      stack_top        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGING_ONLINE: begin
          paging_online <= cfg_data[0];
        end
        CFG_KERNEL_END_FRAME: begin
          kernel_end_frame <= cfg_data;
        end
        CFG_BUMP_START_FRAME: begin
          bump_start_frame <= cfg_data;
          bump_frame       <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      bump_frame <= bump_frame_next;
      stack_top  <= stack_top_next;
    end
  end

  `PFSA_ASSERT_SAME(pop_needs_entry, ctl.pop, !stack_empty && paging_online)
  `PFSA_ASSERT_SAME(push_needs_room, ctl.push, !stack_full && !is_protected)
  `PFSA_ASSERT_NEXT(top_tracks_shift, ctl.push && !cfg_we, stack_top == $past(stack_top) + 1'b1)
  `PFSA_ASSERT_NEXT(bump_never_backs_up, !cfg_we, bump_frame >= $past(bump_frame))
  `PFSA_ASSERT_NEXT(bump_start_loads, cfg_we && cfg_index == CFG_BUMP_START_FRAME,
                    bump_frame == bump_start_frame)
endmodule

// ===== sv/page_frame_stack_allocator_core.sv =====
// Channel   Dir  Payload                              Accepted when
// req       in   operation, frame_in                  req.valid && req.ready
// rsp       out  frame_out, status, free_count        rsp.valid && rsp.ready
// cfg       in   index, data                          cfg.valid && cfg.ready
//
// Every request is decided in the cycle it is accepted and its result sits in the
// output register in the cycle after, so a request is taken every cycle while rsp is
// drained.
// A request waits only while a result is held in the output register and rsp.ready is low.
// Reset is synchronous: it clears the counters, the registers and the output valid;
// the stack cells are not cleared and no clearing pass is needed.
// Configuration writes are always taken in the cycle they are offered.

module page_frame_stack_allocator_core #(
  parameter int STACK_DEPTH = 1024,
  parameter int FRAME_BITS  = 20
) (
  input logic      clk,
  input logic      rst,
  pfsa_req_if.sink req,
  pfsa_rsp_if.source rsp,
  pfsa_cfg_if.sink cfg
);
  import pfsa_pkg::*;

  localparam int COUNT_BITS = $clog2(STACK_DEPTH + 1);

  // The free stack is a chain of cells. Cell 0 holds the most recently freed frame.
  // A push shifts every cell one place deeper and loads the new frame into cell 0;
  // a pop returns cell 0 and shifts every cell one place toward the top. The deepest
  // cell takes back its own value on a pop, which is harmless since entries below
  // the stack top are never read before they are written again.
  logic [FRAME_BITS-1:0] cell_value [STACK_DEPTH];
  cell_ctl_t             cell_ctl;

  logic                  accept;
  logic [FRAME_BITS-1:0] res_frame;
  logic [2:0]            res_status;
  logic [COUNT_BITS-1:0] res_count;

  // The output register decouples the two sides: a new request is taken whenever
  // the register is empty or its item leaves in the same cycle.
  logic                  out_valid;
  logic [FRAME_BITS-1:0] out_frame;
  logic [2:0]            out_status;
  logic [COUNT_BITS-1:0] out_count;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  pfsa_ctrl #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAME_BITS (FRAME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (req.operation),
    .frame_in  (req.frame_in),
    .top_entry (cell_value[0]),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .ctl       (cell_ctl),
    .res_frame (res_frame),
    .res_status(res_status),
    .res_count (res_count)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [FRAME_BITS-1:0] left_value;
    logic [FRAME_BITS-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = req.frame_in;
    end else begin : g_body
      assign left_value = cell_value[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_link
      assign right_value = cell_value[i+1];
    end

    pfsa_cell #(
      .FRAME_BITS(FRAME_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .from_left (left_value),
      .from_right(right_value),
      .value     (cell_value[i])
    );
  end

  // Valid is control state and is reset; the payload is loaded with each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_frame  <= res_frame;
      out_status <= res_status;
      out_count  <= res_count;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.frame_out  = out_frame;
  assign rsp.status     = out_status;
  assign rsp.free_count = out_count;
endmodule

// ===== verif/pfsa_tb_pkg.sv =====
`timescale 1ns / 1ps

package pfsa_tb_pkg;
  import pfsa_pkg::*;

  localparam int FRAME_W     = 20;
  localparam int COUNT_W     = 11;
  localparam int STACK_SLOTS = 1024;
  localparam logic [FRAME_W-1:0] FRAME_TOP = '1;

  // Index past the end of the register list; writes to it change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic [2:0]         status;
    logic [COUNT_W-1:0] count;
  } frame_result_t;

  // Shadow copy of the allocator plus the queue of results it still owes.
  class frame_ledger;
    logic               paging_on;
    logic [FRAME_W-1:0] kernel_end;
    logic [FRAME_W-1:0] bump_ptr;
    logic [FRAME_W-1:0] shadow_stack[STACK_SLOTS];
    int unsigned        stack_fill;
    frame_result_t      owed[$];
    int unsigned        errors;

    function new();
      paging_on  = 1'b0;
      kernel_end = '0;
      bump_ptr   = '0;
      stack_fill = 0;
      errors     = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [FRAME_W-1:0] data);
      case (idx)
        CFG_PAGING_ONLINE:    paging_on = data[0];
        CFG_KERNEL_END_FRAME: kernel_end = data;
        CFG_BUMP_START_FRAME: bump_ptr = data;
        default: ;
      endcase
    endfunction

    function bit frame_guarded(logic [FRAME_W-1:0] f);
      int unsigned limit;
      limit = (bump_ptr >= GUARD_FRAMES) ? bump_ptr - GUARD_FRAMES : 0;
      return (f > limit) || (f > KERNEL_LOW_FRAME && f < kernel_end) ||
             (f < LOW_LIMIT_FRAME);
    endfunction

    // Applies one accepted request to the shadow state and queues its result.
    function void note_request(logic op, logic [FRAME_W-1:0] f);
      frame_result_t r;
      r.frame = '0;
      if (op == OP_ALLOC) begin
        if (!paging_on || stack_fill == 0) begin
          if (bump_ptr == FRAME_TOP) begin
            r.status = STATUS_BUMP_EXHAUSTED;
          end else begin
            bump_ptr = bump_ptr + 1'b1;
            r.frame  = bump_ptr;
            r.status = STATUS_BUMPED;
          end
        end else begin
          stack_fill--;
          r.frame  = shadow_stack[stack_fill];
          r.status = STATUS_POPPED;
        end
      end else if (frame_guarded(f)) begin
        r.status = STATUS_PROTECTED;
      end else if (stack_fill >= STACK_SLOTS) begin
        r.status = STATUS_STACK_FULL;
      end else begin
        shadow_stack[stack_fill] = f;
        stack_fill++;
        r.status = STATUS_FREED;
      end
      r.count = COUNT_W'(stack_fill);
      owed.push_back(r);
    endfunction

    function void check_result(logic [FRAME_W-1:0] frame, logic [2:0] status,
                               logic [COUNT_W-1:0] count);
      frame_result_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: frame_out %h status %0d free_count %0d",
               frame, status, count);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (frame !== want.frame) begin
        $error("frame_out: expected %h, got %h", want.frame, frame);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (count !== want.count) begin
        $error("free_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pfsa_pkg::*;
  import pfsa_tb_pkg::*;

  // Generous bound: even with both sides stalling for the longest gap on every
  // item, the whole run needs well under a quarter of this.
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  // When set, neither side inserts gaps, so back-to-back traffic is exercised.
  bit calm = 1'b0;

  int unsigned cycle_count = 0;

  frame_ledger board = new;

  pfsa_req_if #(.FRAME_BITS(FRAME_W)) req_ch ();
  pfsa_rsp_if #(.FRAME_BITS(FRAME_W), .COUNT_BITS(COUNT_W)) rsp_ch ();
  pfsa_cfg_if #(.DATA_BITS(FRAME_W), .INDEX_BITS(CFG_INDEX_BITS)) cfg_ch ();

  page_frame_stack_allocator_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Offers one request item after a random gap and waits for it to be taken.
  // The request is applied to the shadow model at the edge that accepts it.
  task automatic send_request(input logic op, input logic [FRAME_W-1:0] frame);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.frame_in  <= frame;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(op, frame);
  endtask

  // Leaves cfg valid high so a run of writes never lowers and raises it in one step.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [FRAME_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    board.set_register(idx, data);
  endtask

  // Writes every register, plus the unused index, then drops cfg valid.
  // The paging bit rides on random upper data bits, which must be ignored.
  task automatic configure(input logic paging, input logic [FRAME_W-1:0] kend,
                           input logic [FRAME_W-1:0] bstart);
    write_register(CFG_SPARE_INDEX, FRAME_W'($urandom()));
    write_register(CFG_PAGING_ONLINE, FRAME_W'({$urandom_range(0, 32'h7ffff), paging}));
    write_register(CFG_KERNEL_END_FRAME, kend);
    write_register(CFG_BUMP_START_FRAME, bstart);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stops offering requests and waits until every owed result has been seen,
  // so the block is idle before any register changes.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Chooses a frame to free. With probability tidy_pct it is a frame that
  // passes every protection check (when one exists), so frees actually land on
  // the stack; otherwise it sits on a protection boundary or is fully random.
  function automatic logic [FRAME_W-1:0] pick_free_frame(int unsigned tidy_pct);
    int unsigned limit;
    int unsigned low_hi;
    int unsigned high_lo;
    int unsigned roll;
    limit   = (board.bump_ptr >= GUARD_FRAMES) ? board.bump_ptr - GUARD_FRAMES : 0;
    low_hi  = (limit < KERNEL_LOW_FRAME) ? limit : KERNEL_LOW_FRAME;
    high_lo = (board.kernel_end > KERNEL_LOW_FRAME + 1) ? board.kernel_end
                                                        : KERNEL_LOW_FRAME + 1;
    roll = $urandom_range(0, 99);
    if (roll < tidy_pct && limit >= LOW_LIMIT_FRAME) begin
      if (high_lo <= limit && $urandom_range(0, 3) != 0)
        return FRAME_W'($urandom_range(high_lo, limit));
      return FRAME_W'($urandom_range(LOW_LIMIT_FRAME, low_hi));
    end
    if (roll < tidy_pct + (100 - tidy_pct) / 2) begin
      case ($urandom_range(0, 5))
        0: return FRAME_W'(LOW_LIMIT_FRAME - 1);
        1: return FRAME_W'(KERNEL_LOW_FRAME + 1);
        2: return FRAME_W'(board.kernel_end - 1);
        3: return FRAME_W'(board.kernel_end);
        4: return FRAME_W'(limit);
        default: return FRAME_W'(limit + 1);
      endcase
    end
    return FRAME_W'($urandom());
  endfunction

  // Result side: draws a stall before every item, then holds ready until a
  // result is taken and checks it against the oldest owed result.
  initial begin
    int unsigned gap;
    rsp_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      board.check_result(rsp_ch.frame_out, rsp_ch.status, rsp_ch.free_count);
    end
  end

  initial begin
    int unsigned item_total;
    int unsigned free_pct;
    int unsigned tidy_pct;
    logic        paging;
    logic [FRAME_W-1:0] kend;
    logic [FRAME_W-1:0] bstart;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_ALLOC;
    req_ch.frame_in  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_PAGING_ONLINE;
    cfg_ch.data      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Kernel image ends at frame 0x1000 and the bump pointer
    // starts high, so both protected bands and the guard below the bump
    // pointer have frames on either side of their edges.
    configure(1'b1, 20'h01000, 20'h20000);
    send_request(OP_ALLOC, 20'h00000);  // stack empty, so it bumps to 0x20001
    send_request(OP_FREE, 20'h0001f);   // just below the low limit
    send_request(OP_FREE, 20'h00020);   // lowest frame that may be freed
    send_request(OP_FREE, 20'h00100);   // top of the low band, still allowed
    send_request(OP_FREE, 20'h00101);   // first frame inside the kernel image
    send_request(OP_FREE, 20'h00fff);   // last frame inside the kernel image
    send_request(OP_FREE, 20'h01000);   // first frame past the kernel image
    send_request(OP_FREE, 20'h1fff1);   // exactly at the guard below the bump pointer
    send_request(OP_FREE, 20'h1fff2);   // one frame into the guard
    send_request(OP_FREE, 20'hfffff);   // largest frame number
    // Four pops come back newest first; the fifth finds the stack empty and
    // bumps. The frame field of an allocate is ignored.
    send_request(OP_ALLOC, 20'hfffff);
    send_request(OP_ALLOC, 20'h00000);
    send_request(OP_ALLOC, 20'h55555);
    send_request(OP_ALLOC, 20'haaaaa);
    send_request(OP_ALLOC, 20'h00000);
    settle();

    // Bump pointer one short of the top: one bump succeeds, then it is exhausted.
    configure(1'b0, 20'h00000, 20'hffffe);
    send_request(OP_ALLOC, 20'h00000);
    send_request(OP_ALLOC, 20'h00000);
    send_request(OP_FREE, 20'hfffef);   // the guard limit with the pointer at the top
    send_request(OP_FREE, 20'hffff0);
    // Paging is off, so the waiting stack entry is not used.
    send_request(OP_ALLOC, 20'h00000);
    settle();

    // Bump pointer below the guard size: the guard limit saturates at zero.
    configure(1'b1, 20'h00000, 20'h00005);
    send_request(OP_FREE, 20'h00020);
    send_request(OP_ALLOC, 20'h00000);  // pops the frame freed in the last phase
    send_request(OP_ALLOC, 20'h00000);  // stack empty again, bumps to 6
    send_request(OP_FREE, 20'h00000);
    settle();

    // Random part. Phase 0 and 1 use the register extremes; phase 3 is mostly
    // frees and builds a deep stack that later phases pop. Other phases draw
    // their settings at random.
    for (int ph = 0; ph < 8; ph++) begin
      paging = (ph == 3) ? 1'b1 : 1'($urandom_range(0, 1));
      case (ph)
        0: begin
          kend   = '0;
          bstart = '0;
        end
        1: begin
          kend   = FRAME_TOP;
          bstart = FRAME_TOP;
        end
        3: begin
          kend   = FRAME_W'($urandom_range(0, 32'h800));
          bstart = FRAME_W'($urandom_range(32'h80000, 32'hffff0));
        end
        default: begin
          kend   = ($urandom_range(0, 1) != 0) ? FRAME_W'($urandom_range(0, 32'h2000))
                                               : FRAME_W'($urandom());
          bstart = ($urandom_range(0, 1) != 0) ? FRAME_W'($urandom_range(32'h100, 32'h40000))
                                               : FRAME_W'($urandom());
        end
      endcase
      configure(paging, kend, bstart);

      item_total = (ph == 3) ? 250 : 25;
      free_pct   = (ph == 3) ? 97 : $urandom_range(20, 80);
      tidy_pct   = (ph == 3) ? 95 : 60;
      for (int n = 0; n < item_total; n++) begin
        // Every so often switch between gapped traffic and a stretch without gaps.
        if (n % 24 == 0) calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < free_pct)
          send_request(OP_FREE, pick_free_frame(tidy_pct));
        else
          send_request(OP_ALLOC, FRAME_W'($urandom()));
      end
      settle();
    end

    // All results are in; keep the clock running so any stray result would still show.
    repeat (4) @(posedge clk);
    if (board.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
